@@ hw/rtl/ptw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_pkg: shared types and constants for the page table walker
// Operation codes, status codes, queue entry type and sequencer states.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int MemWordsDefault = 16384;
  localparam int AddrW = 52;
  localparam int FramesW = 6;
  localparam int TableEntries = 512;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_MAP = 2'd1,
    OP_UNMAP = 2'd2,
    OP_XLATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_NOFRAMES = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_ROOT = 2'd0,
    CFG_BASE = 2'd1,
    CFG_FRAMES = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    op_t op;
    logic [47:0] virt_addr;
    logic [63:0] phys_addr;
    logic [63:0] flags;
    logic [63:0] word_value;
  } cmd_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD, S_WAIT, S_CHECK, S_CLEAR, S_LINK, S_LEAF, S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [1:0] status;
    logic [63:0] result_addr;
  } rsp_t;

endpackage

@@ hw/rtl/ptw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ptw_ram #(
  parameter int Width = 64,
  parameter int Depth = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

@@ hw/rtl/ptw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_front: input capture and two-entry command queue
// Accepts transfers and queues them for the sequencer.
// ----------------------------------------------------------------------------
module ptw_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  ptw_pkg::cmd_t  s_cmd,
  output logic           q_valid,
  input  logic           q_pop,
  output ptw_pkg::cmd_t  q_cmd
);
  import ptw_pkg::*;

  cmd_t slot [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic push;

  assign s_tready = (count != 2'd2);
  assign push = s_tvalid && s_tready;
  assign q_valid = (count != 2'd0);
  assign q_cmd = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= s_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

@@ hw/rtl/ptw_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptw_back: walk sequencer
// Runs one command at a time against the table RAM and delivers its response.
// ----------------------------------------------------------------------------
module ptw_back #(
  parameter int MemWords = ptw_pkg::MemWordsDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [ptw_pkg::AddrW-1:0]   cfg_data,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  ptw_pkg::cmd_t               q_cmd,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output ptw_pkg::rsp_t               m_rsp
);
  import ptw_pkg::*;

  localparam int IdxW = $clog2(MemWords);

  seq_state_t state, state_next;
  logic [AddrW-1:0] root_table_addr;
  logic [AddrW-1:0] alloc_base;
  logic [FramesW-1:0] alloc_frames;
  logic [FramesW-1:0] frames_used;

  cmd_t cmd;
  logic [1:0] lvl;
  logic [IdxW-1:0] tbl;
  logic [IdxW-1:0] newtbl;
  logic [IdxW:0] clr_cnt;
  logic rsp_valid;
  rsp_t rsp;

  logic ram_we;
  logic [IdxW-1:0] ram_addr;
  logic [63:0] ram_wdata;
  logic [63:0] ram_rdata;

  logic [8:0] vidx;
  logic [IdxW-1:0] entry_addr;
  logic [63:0] alloc_addr;

  ptw_ram #(.Width(64), .Depth(MemWords)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  always_comb begin
    unique case (lvl)
      2'd0: vidx = cmd.virt_addr[47:39];
      2'd1: vidx = cmd.virt_addr[38:30];
      2'd2: vidx = cmd.virt_addr[29:21];
      default: vidx = cmd.virt_addr[20:12];
    endcase
  end

  assign entry_addr = tbl + IdxW'(vidx);
  assign alloc_addr = {12'd0, alloc_base[AddrW-1:12], 12'd0}
                      + {46'd0, frames_used, 12'd0};

  assign m_tvalid = rsp_valid;
  assign m_rsp = rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_addr <= '0;
      alloc_base <= '0;
      alloc_frames <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROOT: root_table_addr <= cfg_data;
        CFG_BASE: alloc_base <= cfg_data;
        CFG_FRAMES: alloc_frames <= cfg_data[FramesW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      clr_cnt <= '0;
      rsp_valid <= 1'b0;
      frames_used <= '0;
      lvl <= '0;
    end else begin
      state <= state_next;
      if (rsp_valid && m_tready) rsp_valid <= 1'b0;
      unique case (state)
        S_INIT: clr_cnt <= clr_cnt + (IdxW+1)'(1);
        S_IDLE: begin
          if (q_valid && !rsp_valid) begin
            cmd <= q_cmd;
            lvl <= 2'd0;
            tbl <= root_table_addr[IdxW+2:3] & ~IdxW'(9'h1FF);
            rsp.status <= ST_OK;
            rsp.result_addr <= '0;
          end
        end
        S_CHECK: begin
          if (ram_rdata[0]) begin
            if (lvl == 2'd3) begin
              if (cmd.op == OP_XLATE) begin
                rsp.result_addr <= {ram_rdata[63:12], cmd.virt_addr[11:0]};
              end
            end else begin
              tbl <= ram_rdata[IdxW+2:3] & ~IdxW'(9'h1FF);
              lvl <= lvl + 2'd1;
            end
          end else if (cmd.op == OP_MAP) begin
            if (frames_used < alloc_frames) begin
              newtbl <= alloc_addr[IdxW+2:3];
              frames_used <= frames_used + FramesW'(1);
              clr_cnt <= '0;
            end else begin
              rsp.status <= ST_NOFRAMES;
            end
          end else begin
            rsp.status <= ST_UNMAPPED;
          end
        end
        S_CLEAR: clr_cnt <= clr_cnt + (IdxW+1)'(1);
        S_LINK: begin
          tbl <= newtbl;
          lvl <= lvl + 2'd1;
        end
        S_DONE: rsp_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    ram_we = 1'b0;
    ram_addr = entry_addr;
    ram_wdata = '0;
    unique case (state)
      S_INIT: begin
        ram_we = 1'b1;
        ram_addr = clr_cnt[IdxW-1:0];
        if (clr_cnt == (IdxW+1)'(MemWords - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid && !rsp_valid) begin
          q_pop = 1'b1;
          if (q_cmd.op == OP_WRITE) begin
            ram_we = 1'b1;
            ram_addr = q_cmd.phys_addr[IdxW+2:3];
            ram_wdata = q_cmd.word_value;
            state_next = S_DONE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD: state_next = S_WAIT;
      S_WAIT: state_next = S_CHECK;
      S_CHECK: begin
        if (ram_rdata[0]) begin
          if (lvl == 2'd3) begin
            if (cmd.op == OP_UNMAP) ram_we = 1'b1;
            state_next = S_DONE;
          end else if (lvl == 2'd2 && cmd.op == OP_MAP) begin
            state_next = S_LEAF;
          end else begin
            state_next = S_RD;
          end
        end else if (cmd.op == OP_MAP && lvl != 2'd3) begin
          state_next = (frames_used < alloc_frames) ? S_CLEAR : S_DONE;
        end else if (cmd.op == OP_MAP) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = newtbl + clr_cnt[IdxW-1:0];
        if (clr_cnt == (IdxW+1)'(TableEntries - 1)) state_next = S_LINK;
      end
      S_LINK: begin
        ram_we = 1'b1;
        ram_wdata = 64'({newtbl, 3'b000}) | cmd.flags | 64'd1;
        ram_wdata[63:IdxW+3] = ram_wdata[63:IdxW+3] | alloc_addr[63:IdxW+3];
        state_next = (lvl == 2'd2) ? S_LEAF : S_RD;
      end
      S_LEAF: begin
        ram_we = 1'b1;
        ram_wdata = cmd.phys_addr | cmd.flags | 64'd1;
        state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule

@@ hw/rtl/four_level_page_table_walker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_unit: four-level page table walker
// Timing: a write goes straight from the queue to the table RAM; translate/unmap
// read one entry per level through the RD, WAIT and CHECK states (single-port
// table RAM); map clears each new table entry by entry, then links it.
// Throughput: one item at a time in the walk sequencer, 2-entry input queue.
// Reset: synchronous; a clearing pass zeroes every table RAM word before the
// sequencer takes the first item (config writes are taken throughout).
module four_level_page_table_walker_unit #(
  parameter int MEM_WORDS = ptw_pkg::MemWordsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [51:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[1:0], virt_addr[49:2], phys_addr[113:50], flags[177:114], word_value[241:178]
  input  logic [247:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], result_addr[65:2]
  output logic [71:0]  m_axis_tdata
);
  import ptw_pkg::*;

  cmd_t in_cmd;
  cmd_t q_cmd;
  logic q_valid;
  logic q_pop;
  rsp_t rsp;

  assign in_cmd.op = op_t'(s_axis_tdata[1:0]);
  assign in_cmd.virt_addr = s_axis_tdata[49:2];
  assign in_cmd.phys_addr = s_axis_tdata[113:50];
  assign in_cmd.flags = s_axis_tdata[177:114];
  assign in_cmd.word_value = s_axis_tdata[241:178];

  ptw_front u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_cmd(in_cmd),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
  );

  ptw_back #(.MemWords(MEM_WORDS)) u_back (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_rsp(rsp)
  );

  assign m_axis_tdata = {6'd0, rsp.result_addr, rsp.status};
endmodule
